FILE: rtl/ofo_pkg.sv
`default_nettype none

package ofo_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTLIER_LIMIT = 3'd0,
		REG_LOSS_FRAMES   = 3'd1,
		REG_HOLD_FRAMES   = 3'd2,
		REG_MAX_HEIGHT    = 3'd3,
		REG_MIN_HEIGHT    = 3'd4,
		REG_PIXEL_SCALE   = 3'd5,
		REG_FILTER_GAIN   = 3'd6,
		REG_UPDATE_RATE   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [14:0] outlier_limit;
		logic [15:0] loss_frames;
		logic [15:0] hold_frames;
		logic [14:0] max_height_cm;
		logic [14:0] min_height_cm;
		logic [15:0] pixel_scale;
		logic [15:0] filter_gain;
		logic [11:0] update_rate_hz;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		outlier_limit:  15'd100,
		loss_frames:    16'd100,
		hold_frames:    16'd100,
		max_height_cm:  15'd400,
		min_height_cm:  15'd5,
		pixel_scale:    16'd13972,
		filter_gain:    16'd9830,
		update_rate_hz: 12'd100
	};

	// fixed-point constants
	localparam logic [13:0]        ROUND_POS  = 14'd12800;   // half of 25600
	localparam logic [6:0]         DIV_CONST  = 7'd100;      // 25600 = 256 * 100
	localparam logic [15:0]        ROUND_GAIN = 16'd32768;   // half of 65536
	localparam logic [40:0]        V_SAT      = 41'h100_0000_0000;
	localparam logic signed [16:0] VEL_MAX    = 17'sd38400;
	localparam logic signed [16:0] VEL_MIN    = -17'sd38400;

	// divider by 100: one quotient digit a cycle over the dividend
	localparam int DIV_W      = 56;
	localparam int DIGIT_W    = 14;
	localparam int DIV_STEPS  = DIV_W / DIGIT_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// digit by reciprocal: floor(t / 100) = (t * RECIP_100) >> RECIP_SHIFT for t < 2^21
	localparam int          DT_W        = DIGIT_W + 7;
	localparam int          RECIP_W     = 22;
	localparam int          DPROD_W     = DT_W + RECIP_W;
	localparam int          RECIP_SHIFT = 28;
	localparam logic [21:0] RECIP_100   = 22'd2684355;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FRONT,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV,
		ST_VMUL,
		ST_VSUM,
		ST_VERR,
		ST_FMUL,
		ST_FADD,
		ST_WRITE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FRONT,
		OP_DIFF,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_DIV,
		OP_VMUL,
		OP_VSUM,
		OP_VERR,
		OP_FMUL,
		OP_FADD,
		OP_WRITE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic axis;
	} dp_cmd_t;

	typedef struct packed {
		logic upd;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/optical_flow_odometry.sv
`default_nettype none

// Optical-flow odometry. Each input item is one sensor frame (pixel deltas, raw image
// min and max, height) and gives exactly one result item with filtered velocity,
// integrated position and status. One item is worked on at a time: a frame that
// updates the position runs the per-axis sequence of scale multiplies, the division
// by 100 that resolves fourteen quotient bits a cycle, and the velocity filter, run
// once for X and once for Y on one shared datapath; a frame that does not update
// skips these and goes to the output register. A finished result waits in the output
// register while the next frame is accepted. The user must write configuration
// registers only while the block is idle; the block itself does not enforce this.
module optical_flow_odometry (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ofo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ofo_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [15:0]              delta_x,
	input  wire logic signed [15:0]              delta_y,
	input  wire logic [7:0]                      raw_min,
	input  wire logic [7:0]                      raw_max,
	input  wire logic signed [15:0]              height_cm,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [16:0]                   velocity_x,
	output logic signed [16:0]                   velocity_y,
	output logic signed [31:0]                   position_x,
	output logic signed [31:0]                   position_y,
	output logic                                 updated,
	output logic                                 flow_ok,
	output logic                                 data_valid,
	output logic [7:0]                           outlier_count
);
	import ofo_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OUTLIER_LIMIT: cfg_q.outlier_limit  <= cfg_data[14:0];
				REG_LOSS_FRAMES:   cfg_q.loss_frames    <= cfg_data;
				REG_HOLD_FRAMES:   cfg_q.hold_frames    <= cfg_data;
				REG_MAX_HEIGHT:    cfg_q.max_height_cm  <= cfg_data[14:0];
				REG_MIN_HEIGHT:    cfg_q.min_height_cm  <= cfg_data[14:0];
				REG_PIXEL_SCALE:   cfg_q.pixel_scale    <= cfg_data;
				REG_FILTER_GAIN:   cfg_q.filter_gain    <= cfg_data;
				REG_UPDATE_RATE:   cfg_q.update_rate_hz <= cfg_data[11:0];
			endcase
		end
	end

	ofo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ofo_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg           (cfg_q),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.raw_min       (raw_min),
		.raw_max       (raw_max),
		.height_cm     (height_cm),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.velocity_x    (velocity_x),
		.velocity_y    (velocity_y),
		.position_x    (position_x),
		.position_y    (position_y),
		.updated       (updated),
		.flow_ok       (flow_ok),
		.data_valid    (data_valid),
		.outlier_count (outlier_count)
	);

endmodule

`default_nettype wire

FILE: rtl/ofo_ctrl.sv
`default_nettype none

module ofo_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire ofo_pkg::dp_stat_t stat,
	output ofo_pkg::dp_cmd_t      cmd
);
	import ofo_pkg::*;

	state_t               state_q, state_nx;
	logic                 axis_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 div_last;

	assign div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_FRONT;
			ST_FRONT:  state_nx = stat.upd ? ST_DIFF : ST_WRITE;
			ST_DIFF:   state_nx = ST_MUL_LO;
			ST_MUL_LO: state_nx = ST_MUL_HI;
			ST_MUL_HI: state_nx = ST_DIV;
			ST_DIV:    if (div_last) state_nx = ST_VMUL;
			ST_VMUL:   state_nx = ST_VSUM;
			ST_VSUM:   state_nx = ST_VERR;
			ST_VERR:   state_nx = ST_FMUL;
			ST_FMUL:   state_nx = ST_FADD;
			ST_FADD:   state_nx = axis_q ? ST_WRITE : ST_DIFF;
			ST_WRITE:  if (stat.out_free) state_nx = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.axis = axis_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_FRONT:  cmd.op = OP_FRONT;
			ST_DIFF:   cmd.op = OP_DIFF;
			ST_MUL_LO: cmd.op = OP_MUL_LO;
			ST_MUL_HI: cmd.op = OP_MUL_HI;
			ST_DIV:    cmd.op = OP_DIV;
			ST_VMUL:   cmd.op = OP_VMUL;
			ST_VSUM:   cmd.op = OP_VSUM;
			ST_VERR:   cmd.op = OP_VERR;
			ST_FMUL:   cmd.op = OP_FMUL;
			ST_FADD:   cmd.op = OP_FADD;
			ST_WRITE:  cmd.op = stat.out_free ? OP_WRITE : OP_NONE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// state, axis and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_FRONT) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_FADD) begin
				axis_q <= 1'b1;
			end
			if (state_q == ST_DIV && !div_last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_front: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_FRONT))
		else $error("accepted item did not reach front step");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (cnt_q == '0))
		else $error("divider count running outside division");

	a_write_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && !stat.out_free) |=> (state_q == ST_WRITE))
		else $error("result dropped while output register full");
`endif

endmodule

`default_nettype wire

FILE: rtl/ofo_dp.sv
`default_nettype none

module ofo_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ofo_pkg::dp_cmd_t    cmd,
	output ofo_pkg::dp_stat_t        stat,
	input  wire ofo_pkg::cfg_t       cfg,
	input  wire logic signed [15:0]  delta_x,
	input  wire logic signed [15:0]  delta_y,
	input  wire logic [7:0]          raw_min,
	input  wire logic [7:0]          raw_max,
	input  wire logic signed [15:0]  height_cm,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [16:0]       velocity_x,
	output logic signed [16:0]       velocity_y,
	output logic signed [31:0]       position_x,
	output logic signed [31:0]       position_y,
	output logic                     updated,
	output logic                     flow_ok,
	output logic                     data_valid,
	output logic [7:0]               outlier_count
);
	import ofo_pkg::*;

	// captured item
	logic signed [16:0] d_q [2];
	logic signed [15:0] h_q;
	logic               rz_q;

	// block state
	logic [31:0]        sum_q [2];
	logic [31:0]        last_q [2];
	logic [31:0]        pos_q [2];
	logic signed [16:0] vf_q [2];
	logic [15:0]        zfc_q;
	logic [15:0]        hold_q;
	logic               valid_q;
	logic [7:0]         reject_q;
	logic               ok_q;
	logic               upd_q;

	// working registers
	logic [30:0]        k_q;
	logic               neg_q;
	logic [31:0]        mag_q;
	logic [62:0]        acc_q;
	logic [DIV_W-1:0]   dq_q;
	logic [6:0]         rem_q;
	logic               vbig_q;
	logic [31:0]        plo_q;
	logic [31:0]        phi_q;
	logic signed [41:0] vs_q;
	logic               eneg_q;
	logic [40:0]        emag_q;
	logic [56:0]        fp_q;

	// output register
	logic               out_valid_q;
	logic signed [16:0] ovx_q, ovy_q;
	logic [31:0]        opx_q, opy_q;
	logic               oupd_q, ook_q, oval_q;
	logic [7:0]         orej_q;

	logic               ax;
	logic signed [16:0] dy_ext;

	assign ax     = cmd.axis;
	assign dy_ext = {delta_y[15], delta_y};

	// front step: loss, outlier and height decisions
	logic        ok_c, inlier_c, upd_c, below_min_c;
	logic [16:0] ax_c, ay_c;
	logic [14:0] hs_c;
	logic [30:0] k_c;

	always_comb begin
		ok_c        = !(rz_q && (zfc_q > cfg.loss_frames));
		ax_c        = d_q[0][16] ? 17'(-d_q[0]) : 17'(d_q[0]);
		ay_c        = d_q[1][16] ? 17'(-d_q[1]) : 17'(d_q[1]);
		inlier_c    = (ax_c < {2'b00, cfg.outlier_limit}) &&
			(ay_c < {2'b00, cfg.outlier_limit});
		upd_c       = ok_c && ($signed({h_q[15], h_q}) < $signed({2'b00, cfg.max_height_cm}));
		below_min_c = $signed({h_q[15], h_q}) < $signed({2'b00, cfg.min_height_cm});
		hs_c        = below_min_c ? 15'd0 : h_q[14:0];
		k_c         = 31'(cfg.pixel_scale) * 31'(hs_c);
	end

	// pixel change and scale products
	logic [31:0] dpix_c;
	logic [46:0] plo_c, phi_c;
	logic [62:0] xsum_c;

	assign dpix_c = sum_q[ax] - last_q[ax];
	assign plo_c  = 47'(k_q) * 47'(mag_q[15:0]);
	assign phi_c  = 47'(k_q) * 47'(mag_q[31:16]);
	assign xsum_c = acc_q + {phi_c, 16'b0};

	// divide by 100, one quotient digit a cycle by reciprocal multiplication
	logic [DIV_W-1:0]   dq_nx;
	logic [6:0]         rem_nx;
	logic [DT_W-1:0]    dt_c;
	logic [DPROD_W-1:0] dprod_c;
	logic [DIGIT_W-1:0] qd_c;

	always_comb begin
		dt_c    = {rem_q, dq_q[DIV_W-1 -: DIGIT_W]};
		dprod_c = DPROD_W'(dt_c) * DPROD_W'(RECIP_100);
		qd_c    = dprod_c[RECIP_SHIFT +: DIGIT_W];
		rem_nx  = 7'(dt_c - DT_W'(qd_c) * DT_W'(DIV_CONST));
		dq_nx   = {dq_q[DIV_W-DIGIT_W-1:0], qd_c};
	end

	// velocity products, saturation and filter
	logic [48:0]        qm_c;
	logic [31:0]        step_c;
	logic [51:0]        vm_c;
	logic               vsat_c;
	logic [40:0]        vclip_c;
	logic signed [42:0] e_c;
	logic [40:0]        corr_c;
	logic signed [42:0] nv_c;
	logic signed [16:0] vclamp_c;

	always_comb begin
		qm_c    = dq_q[48:0];
		step_c  = neg_q ? 32'(-dq_q[31:0]) : dq_q[31:0];
		vm_c    = {phi_q, 20'b0} + 52'(plo_q);
		vsat_c  = (vbig_q && (cfg.update_rate_hz != '0)) || (vm_c > 52'(V_SAT));
		vclip_c = vsat_c ? V_SAT : vm_c[40:0];
		e_c     = 43'(vs_q) - 43'(vf_q[ax]);
		corr_c  = fp_q[56:16];
		nv_c    = 43'(vf_q[ax]) + (eneg_q ? -$signed({2'b00, corr_c}) : $signed({2'b00, corr_c}));
		if (nv_c > 43'(VEL_MAX)) begin
			vclamp_c = VEL_MAX;
		end else if (nv_c < 43'(VEL_MIN)) begin
			vclamp_c = VEL_MIN;
		end else begin
			vclamp_c = 17'(nv_c);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d_q[0] <= {delta_x[15], delta_x};
				d_q[1] <= -dy_ext;
				h_q    <= height_cm;
				rz_q   <= (raw_min == 8'd0) && (raw_max == 8'd0);
			end
			OP_FRONT:  k_q <= k_c;
			OP_DIFF: begin
				neg_q <= dpix_c[31];
				mag_q <= dpix_c[31] ? 32'(-dpix_c) : dpix_c;
			end
			OP_MUL_LO: acc_q <= 63'(plo_c) + 63'(ROUND_POS);
			OP_MUL_HI: dq_q  <= {1'b0, xsum_c[62:8]};
			OP_DIV:    dq_q  <= dq_nx;
			OP_VMUL: begin
				vbig_q <= |qm_c[48:40];
				plo_q  <= 32'(qm_c[19:0]) * 32'(cfg.update_rate_hz);
				phi_q  <= 32'(qm_c[39:20]) * 32'(cfg.update_rate_hz);
			end
			OP_VSUM:   vs_q <= neg_q ? -$signed({1'b0, vclip_c}) : $signed({1'b0, vclip_c});
			OP_VERR: begin
				eneg_q <= e_c[42];
				emag_q <= e_c[42] ? 41'(-e_c) : 41'(e_c);
			end
			OP_FMUL:   fp_q <= 57'(emag_q) * 57'(cfg.filter_gain) + 57'(ROUND_GAIN);
			default: ;
		endcase
	end

	// block state and divider remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				sum_q[i]  <= '0;
				last_q[i] <= '0;
				pos_q[i]  <= '0;
				vf_q[i]   <= '0;
			end
			zfc_q    <= '0;
			hold_q   <= '0;
			valid_q  <= 1'b0;
			reject_q <= '0;
			ok_q     <= 1'b0;
			upd_q    <= 1'b0;
			rem_q    <= '0;
		end else begin
			case (cmd.op)
				OP_FRONT: begin
					ok_q  <= ok_c;
					upd_q <= upd_c;
					if (rz_q) begin
						if (zfc_q != 16'hFFFF) zfc_q <= zfc_q + 1'b1;
					end else begin
						zfc_q <= '0;
					end
					if (ok_c && !inlier_c) begin
						reject_q <= reject_q + 1'b1;
					end
					if (upd_c) begin
						hold_q  <= '0;
						valid_q <= 1'b1;
					end else if (valid_q) begin
						if (hold_q > cfg.hold_frames) begin
							hold_q  <= '0;
							valid_q <= 1'b0;
						end else if (hold_q != 16'hFFFF) begin
							hold_q <= hold_q + 1'b1;
						end
					end
					// unusable step while data is valid clears the sums, otherwise inliers accumulate
					if (!upd_c && valid_q) begin
						for (int i = 0; i < 2; i++) begin
							sum_q[i]  <= '0;
							last_q[i] <= '0;
						end
					end else if (ok_c && inlier_c) begin
						for (int i = 0; i < 2; i++) begin
							sum_q[i] <= sum_q[i] + 32'(d_q[i]);
						end
					end
				end
				OP_DIFF:   last_q[ax] <= sum_q[ax];
				OP_MUL_HI: rem_q <= '0;
				OP_DIV:    rem_q <= rem_nx;
				OP_VMUL:   pos_q[ax] <= pos_q[ax] + step_c;
				OP_FADD:   vf_q[ax] <= vclamp_c;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_WRITE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE) begin
			ovx_q  <= vf_q[0];
			ovy_q  <= vf_q[1];
			opx_q  <= pos_q[0];
			opy_q  <= pos_q[1];
			oupd_q <= upd_q;
			ook_q  <= ok_q;
			oval_q <= valid_q;
			orej_q <= reject_q;
		end
	end

	assign stat.upd      = upd_c;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign velocity_x    = ovx_q;
	assign velocity_y    = ovy_q;
	assign position_x    = $signed(opx_q);
	assign position_y    = $signed(opy_q);
	assign updated       = oupd_q;
	assign flow_ok       = ook_q;
	assign data_valid    = oval_q;
	assign outlier_count = orej_q;

`ifndef ASSERT_OFF
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < DIV_CONST)
		else $error("divider remainder out of range");

	a_vf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vf_q[0] <= VEL_MAX) && (vf_q[0] >= VEL_MIN) &&
		(vf_q[1] <= VEL_MAX) && (vf_q[1] >= VEL_MIN))
		else $error("filtered velocity beyond clamp");

	a_quot_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_VMUL) |-> (dq_q[DIV_W-1:49] == '0))
		else $error("position step quotient too wide");
`endif

endmodule

`default_nettype wire

FILE: verif/optical_flow_odometry_tb.sv
`timescale 1ns / 100ps

// one sensor frame as offered to the block
typedef struct {
	logic signed [15:0] dx;
	logic signed [15:0] dy;
	logic [7:0]         rmin;
	logic [7:0]         rmax;
	logic signed [15:0] height;
} frame_t;

// one velocity and position estimate as returned by the block
typedef struct {
	logic signed [16:0] vx;
	logic signed [16:0] vy;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic               upd;
	logic               ok;
	logic               valid;
	logic [7:0]         outliers;
} estimate_t;

// tracks the odometry state, predicts each estimate and checks what the block returns
class odometry_tracker;
	ofo_pkg::cfg_t cfg;
	bit [31:0]     pix_sum[2];
	bit [31:0]     pix_last[2];
	bit [31:0]     pos_sum[2];
	longint        vel_filt[2];
	int            zero_run;
	int            hold_run;
	bit            data_ok;
	bit [7:0]      rejects;
	estimate_t     expected_estimates[$];
	int            failures;
	int            reported;
	int            checked;

	function new();
		cfg = ofo_pkg::CFG_RESET;
	endfunction

	function void set_register(ofo_pkg::cfg_reg_t idx, logic [15:0] val);
		case (idx)
			ofo_pkg::REG_OUTLIER_LIMIT: cfg.outlier_limit  = val[14:0];
			ofo_pkg::REG_LOSS_FRAMES:   cfg.loss_frames    = val;
			ofo_pkg::REG_HOLD_FRAMES:   cfg.hold_frames    = val;
			ofo_pkg::REG_MAX_HEIGHT:    cfg.max_height_cm  = val[14:0];
			ofo_pkg::REG_MIN_HEIGHT:    cfg.min_height_cm  = val[14:0];
			ofo_pkg::REG_PIXEL_SCALE:   cfg.pixel_scale    = val;
			ofo_pkg::REG_FILTER_GAIN:   cfg.filter_gain    = val;
			ofo_pkg::REG_UPDATE_RATE:   cfg.update_rate_hz = val[11:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_estimates.size();
	endfunction

	// divide with rounding to nearest, ties away from zero
	function longint rounded_quotient(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function void take_frame(frame_t f);
		longint    d[2];
		longint    h;
		longint    hs;
		longint    lim;
		longint    dpix;
		longint    dpos;
		longint    v;
		longint    vf;
		longint    vsat;
		bit        ok;
		bit        upd;
		bit [31:0] diff;
		estimate_t e;
		int        i;
		vsat = longint'(1) << 40;
		d[0] = f.dx;
		d[1] = -longint'(f.dy);
		h = f.height;
		ok = 1'b1;
		upd = 1'b0;

		// loss detection on frames with no raw image data
		if (f.rmin == 8'd0 && f.rmax == 8'd0) begin
			if (zero_run > int'(cfg.loss_frames))
				ok = 1'b0;
			if (zero_run < 65535)
				zero_run++;
		end else begin
			zero_run = 0;
		end

		// accumulate small deltas, count the rest as outliers
		if (ok) begin
			lim = longint'(cfg.outlier_limit);
			if ((d[0] < 0 ? -d[0] : d[0]) < lim && (d[1] < 0 ? -d[1] : d[1]) < lim) begin
				for (i = 0; i < 2; i++)
					pix_sum[i] = pix_sum[i] + 32'(d[i]);
			end else begin
				rejects = rejects + 8'd1;
			end
		end

		// position step, filtered velocity and integration
		if (ok && h < longint'(cfg.max_height_cm)) begin
			hs = (h < longint'(cfg.min_height_cm)) ? 0 : h;
			hold_run = 0;
			data_ok = 1'b1;
			upd = 1'b1;
			for (i = 0; i < 2; i++) begin
				diff = pix_sum[i] - pix_last[i];
				dpix = longint'($signed(diff));
				dpos = rounded_quotient(longint'(cfg.pixel_scale) * hs * dpix, 25600);
				pix_last[i] = pix_sum[i];
				v = dpos * longint'(cfg.update_rate_hz);
				if (v > vsat)
					v = vsat;
				else if (v < -vsat)
					v = -vsat;
				vf = vel_filt[i];
				vf = vf + rounded_quotient((v - vf) * longint'(cfg.filter_gain), 65536);
				if (vf > 38400)
					vf = 38400;
				else if (vf < -38400)
					vf = -38400;
				vel_filt[i] = vf;
				pos_sum[i] = pos_sum[i] + 32'(dpos);
			end
		end else if (data_ok) begin
			// unusable step: hold timer, sums cleared
			if (hold_run > int'(cfg.hold_frames)) begin
				hold_run = 0;
				data_ok = 1'b0;
			end else if (hold_run < 65535) begin
				hold_run++;
			end
			for (i = 0; i < 2; i++) begin
				pix_sum[i] = '0;
				pix_last[i] = '0;
			end
		end

		e.vx = 17'(vel_filt[0]);
		e.vy = 17'(vel_filt[1]);
		e.px = pos_sum[0];
		e.py = pos_sum[1];
		e.upd = upd;
		e.ok = ok;
		e.valid = data_ok;
		e.outliers = rejects;
		expected_estimates.push_back(e);
	endfunction

	function void compare_field(string name, logic signed [31:0] want,
			logic signed [31:0] seen);
		if (seen !== want) begin
			failures++;
			if (reported < 10)
				$display("estimate %0d %s: expected %0d, got %0d", checked, name, want, seen);
			reported++;
		end
	endfunction

	function void check_estimate(estimate_t got);
		estimate_t want;
		checked++;
		if (expected_estimates.size() == 0) begin
			failures++;
			if (reported < 10)
				$display("estimate %0d arrived with no frame pending", checked);
			reported++;
		end else begin
			want = expected_estimates.pop_front();
			compare_field("velocity_x", want.vx, got.vx);
			compare_field("velocity_y", want.vy, got.vy);
			compare_field("position_x", want.px, got.px);
			compare_field("position_y", want.py, got.py);
			compare_field("updated", want.upd, got.upd);
			compare_field("flow_ok", want.ok, got.ok);
			compare_field("data_valid", want.valid, got.valid);
			compare_field("outlier_count", want.outliers, got.outliers);
		end
	endfunction
endclass

module optical_flow_odometry_tb;
	import ofo_pkg::*;

	localparam int PHASES          = 8;
	localparam int PHASE_FRAMES    = 210;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_AFTER  = 400;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int CALM_FROM       = 900;
	localparam int CALM_TO         = 1200;
	localparam int SETTLE_CYCLES   = 60;

	typedef enum {SEG_TRACK, SEG_DROPOUT, SEG_HIGH, SEG_NOISE} seg_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic signed [15:0]    delta_x;
	logic signed [15:0]    delta_y;
	logic [7:0]            raw_min;
	logic [7:0]            raw_max;
	logic signed [15:0]    height_cm;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [16:0]    velocity_x;
	logic signed [16:0]    velocity_y;
	logic signed [31:0]    position_x;
	logic signed [31:0]    position_y;
	logic                  updated;
	logic                  flow_ok;
	logic                  data_valid;
	logic [7:0]            outlier_count;

	odometry_tracker odometry;
	int              frames_sent;
	int              results_seen;
	int              idle_cycles;
	bit              held_off;

	optical_flow_odometry uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic frame_t make_frame(int dx, int dy, int rmin, int rmax, int h);
		frame_t f;
		f.dx = 16'(dx);
		f.dy = 16'(dy);
		f.rmin = 8'(rmin);
		f.rmax = 8'(rmax);
		f.height = 16'(h);
		return f;
	endfunction

	// delta near or below the outlier limit, sometimes right on it
	function automatic int track_delta(int lim);
		int mag;
		case ($urandom_range(9))
			0: mag = lim;
			1: mag = lim - 1;
			2: mag = $urandom_range(lim - 1, 0);
			default: mag = $urandom_range((lim > 40) ? 40 : lim - 1, 0);
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic int pick(int lo, int hi, int typ);
		case ($urandom_range(7))
			0: return lo;
			1: return hi;
			2, 3, 4: return $urandom_range(typ, lo);
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic frame_t random_frame(seg_kind_t kind);
		int lim;
		int mn;
		int mx;
		int rmin;
		int rmax;
		int h;
		if (kind == SEG_NOISE)
			return make_frame($urandom, $urandom, $urandom, $urandom, $urandom);
		lim = int'(odometry.cfg.outlier_limit);
		mn = int'(odometry.cfg.min_height_cm);
		mx = int'(odometry.cfg.max_height_cm);
		rmin = $urandom_range(255);
		rmax = $urandom_range(255);
		if (kind == SEG_DROPOUT) begin
			rmin = 0;
			rmax = 0;
		end else if (rmin == 0 && rmax == 0) begin
			rmax = $urandom_range(255, 1);
		end
		// heights around the thresholds, negative ones and ordinary flight
		if (kind == SEG_HIGH) begin
			h = $urandom_range(32767, mx);
		end else begin
			case ($urandom_range(9))
				0: h = mn - 1;
				1: h = mn;
				2: h = mx - 1;
				3: h = -int'($urandom_range(32768, 1));
				default: h = (mx > 0) ? int'($urandom_range(mx - 1, 0)) : -1;
			endcase
		end
		return make_frame(track_delta(lim), track_delta(lim), rmin, rmax, h);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		odometry.set_register(idx, val);
	endtask

	task automatic set_config(cfg_t c);
		write_reg(REG_OUTLIER_LIMIT, 16'(c.outlier_limit));
		write_reg(REG_LOSS_FRAMES, c.loss_frames);
		write_reg(REG_HOLD_FRAMES, c.hold_frames);
		write_reg(REG_MAX_HEIGHT, 16'(c.max_height_cm));
		write_reg(REG_MIN_HEIGHT, 16'(c.min_height_cm));
		write_reg(REG_PIXEL_SCALE, c.pixel_scale);
		write_reg(REG_FILTER_GAIN, c.filter_gain);
		write_reg(REG_UPDATE_RATE, 16'(c.update_rate_hz));
	endtask

	// offer one frame, with random idle cycles ahead of it
	task automatic send_frame(frame_t f);
		@(negedge clk);
		while (!(frames_sent >= CALM_FROM && frames_sent < CALM_TO)
				&& $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		delta_x <= f.dx;
		delta_y <= f.dy;
		raw_min <= f.rmin;
		raw_max <= f.rmax;
		height_cm <= f.height;
		do @(posedge clk); while (in_stall);
		odometry.take_frame(f);
		frames_sent++;
	endtask

	// stop offering and wait for every pending estimate
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (odometry.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// stimulus
	initial begin
		int        phase;
		int        sent;
		int        seg_len;
		int        r;
		seg_kind_t kind;
		cfg_t      c;
		odometry = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		delta_x = '0;
		delta_y = '0;
		raw_min = '0;
		raw_max = '0;
		height_cm = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed frames under the reset settings
		send_frame(make_frame(0, 0, 10, 200, 100));
		send_frame(make_frame(99, -99, 1, 2, 399));
		send_frame(make_frame(100, 5, 3, 250, 200));
		send_frame(make_frame(5, 100, 3, 250, 200));
		send_frame(make_frame(-32768, -32768, 255, 255, 32767));
		send_frame(make_frame(32767, 32767, 0, 255, -32768));
		send_frame(make_frame(50, -50, 7, 9, 4));
		send_frame(make_frame(3, 7, 7, 9, 5));
		send_frame(make_frame(20, 20, 7, 9, 400));
		send_frame(make_frame(-1, 1, 0, 0, 100));

		// directed frames with wide limits, fast loss and a short hold
		drain();
		set_config('{outlier_limit: 15'd32767, loss_frames: 16'd1, hold_frames: 16'd1,
			max_height_cm: 15'd32767, min_height_cm: 15'd0, pixel_scale: 16'd65535,
			filter_gain: 16'd65535, update_rate_hz: 12'd4095});
		send_frame(make_frame(32766, 32766, 1, 1, 32766));
		send_frame(make_frame(-32766, -32766, 128, 1, 32766));
		// flow lost on the third blank frame, valid dropped after the hold runs out
		repeat (5) send_frame(make_frame(-2, 3, 0, 0, 60));
		send_frame(make_frame(1, 1, 0, 0, 60));
		send_frame(make_frame(32767, 0, 0, 3, 1000));
		send_frame(make_frame(7, -7, 5, 9, -1));

		// random phases, each under its own settings
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase == 0) begin
				c = '{outlier_limit: 15'd1, loss_frames: 16'd1, hold_frames: 16'd1,
					max_height_cm: 15'd0, min_height_cm: 15'd0, pixel_scale: 16'd0,
					filter_gain: 16'd0, update_rate_hz: 12'd1};
			end else if (phase == 1) begin
				c = '{outlier_limit: 15'd32767, loss_frames: 16'd65535,
					hold_frames: 16'd65535, max_height_cm: 15'd32767, min_height_cm: 15'd0,
					pixel_scale: 16'd65535, filter_gain: 16'd65535, update_rate_hz: 12'd4095};
			end else begin
				c.outlier_limit = 15'(pick(1, 32767, 200));
				c.loss_frames = 16'(pick(1, 65535, 24));
				c.hold_frames = 16'(pick(1, 65535, 24));
				c.max_height_cm = 15'(pick(0, 32767, 3000));
				c.min_height_cm = 15'(pick(0, 32767, 100));
				c.pixel_scale = 16'(pick(0, 65535, 65535));
				c.filter_gain = 16'(pick(0, 65535, 65535));
				c.update_rate_hz = 12'(pick(1, 4095, 4095));
			end
			set_config(c);
			sent = 0;
			while (sent < PHASE_FRAMES) begin
				r = $urandom_range(99);
				kind = (r < 60) ? SEG_TRACK : (r < 72) ? SEG_DROPOUT :
					(r < 84) ? SEG_HIGH : SEG_NOISE;
				seg_len = $urandom_range(24, 1);
				// bursts long enough to run out the loss or hold limits
				if (kind == SEG_DROPOUT && c.loss_frames <= 64 && $urandom_range(1))
					seg_len = int'(c.loss_frames) + $urandom_range(6, 2);
				if (kind == SEG_HIGH && c.hold_frames <= 64 && $urandom_range(1))
					seg_len = int'(c.hold_frames) + $urandom_range(6, 2);
				repeat (seg_len) begin
					send_frame(random_frame(kind));
					sent++;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (odometry.failures == 0 && odometry.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver stall, with one long hold-off to back the block up
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			out_stall <= !(results_seen >= CALM_FROM && results_seen < CALM_TO)
				&& ($urandom_range(99) < 31);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			odometry.check_estimate(estimate_t'{vx: velocity_x, vy: velocity_y,
				px: position_x, py: position_y, upd: updated, ok: flow_ok,
				valid: data_valid, outliers: outlier_count});
			results_seen <= results_seen + 1;
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: optical_flow_odometry.f
rtl/ofo_pkg.sv
rtl/ofo_ctrl.sv
rtl/ofo_dp.sv
rtl/optical_flow_odometry.sv
verif/optical_flow_odometry_tb.sv
